// File: sv/gtd_pkg.sv
// Shared widths, constants and register codes for the gamepad tank-drive mapper.
package gtd_pkg;

  localparam int IN_W       = 17;
  localparam int PAD_W      = 2;
  localparam int CMP_W      = 16;
  localparam int DEG_W      = 8;
  localparam int DUTY_W     = 13;
  localparam int DZ_W       = 16;

  localparam int A_W        = 9;
  localparam int G_W        = 10;
  localparam int M_W        = 16;
  localparam int P_W        = 27;
  localparam int CNT_W      = 5;

  localparam int GAIN_FRAC  = 8;
  localparam int STICK_FRAC = 15;
  localparam int SPEED_MAX  = 255;
  localparam int TURRET_SPD = 128;
  localparam int MOUNT_STEP = 5;
  localparam int SERVO_OFS  = 45;
  localparam int SERVO_DIV  = 1800;
  localparam int PWM_DIV    = 255;

  localparam int DUTY_BITS_DEF = 13;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  localparam logic [DZ_W-1:0]  DEADZONE_RST  = 16'd3277;
  localparam logic [G_W-1:0]   GAIN_RST      = 10'd256;
  localparam logic [CMP_W-1:0] PERIOD_RST    = 16'd2000;
  localparam logic [DEG_W-1:0] MOUNT_MIN_RST = 8'd0;
  localparam logic [DEG_W-1:0] MOUNT_MAX_RST = 8'd180;
  localparam logic [DEG_W-1:0] ANGLE_RST     = 8'd90;

  typedef enum logic [2:0] {
    REG_DEADZONE   = 3'd0,
    REG_LEFT_GAIN  = 3'd1,
    REG_RIGHT_GAIN = 3'd2,
    REG_PERIOD     = 3'd3,
    REG_MOUNT_MIN  = 3'd4,
    REG_MOUNT_MAX  = 3'd5
  } reg_idx_t;

endpackage

// File: sv/gtd_lane.sv
// Bit-serial lane: ((a * g) >> 8) * m, then restoring division by a constant.
module gtd_lane #(
  parameter int DIV_VAL = gtd_pkg::PWM_DIV
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [gtd_pkg::A_W-1:0] a,
  input  logic [gtd_pkg::G_W-1:0] g,
  input  logic [gtd_pkg::M_W-1:0] m,
  output logic                    done,
  output logic [gtd_pkg::P_W-1:0] q
);
  import gtd_pkg::*;

  localparam int RW = $clog2(DIV_VAL + 1);

  typedef enum logic [1:0] {
    L_IDLE,
    L_MUL1,
    L_MUL2,
    L_DIV
  } lphase_t;

  lphase_t          phase_r;
  logic [CNT_W-1:0] cnt_r;
  logic [P_W-1:0]   acc_r;
  logic [P_W-1:0]   mcand_r;
  logic [M_W-1:0]   mplier_r;
  logic [RW-1:0]    rem_r;
  logic             done_r;

  logic [P_W-1:0]   acc_nxt;
  logic [RW:0]      trial;
  logic [RW:0]      diff;
  logic             fits;

  assign acc_nxt = mplier_r[0] ? acc_r + mcand_r : acc_r;
  assign trial   = {rem_r, acc_r[P_W-1]};
  assign fits    = trial >= (RW+1)'(DIV_VAL);
  assign diff    = trial - (RW+1)'(DIV_VAL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= L_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= (phase_r == L_DIV) && (cnt_r == '0);
      case (phase_r)
        L_IDLE: begin
          if (start) begin
            acc_r    <= '0;
            mcand_r  <= P_W'(a);
            mplier_r <= M_W'(g);
            cnt_r    <= CNT_W'(G_W - 1);
            phase_r  <= L_MUL1;
          end
        end
        L_MUL1: begin
          if (cnt_r == '0) begin
            acc_r    <= '0;
            mcand_r  <= acc_nxt >> GAIN_FRAC;
            mplier_r <= m;
            cnt_r    <= CNT_W'(M_W - 1);
            phase_r  <= L_MUL2;
          end else begin
            acc_r    <= acc_nxt;
            mcand_r  <= mcand_r << 1;
            mplier_r <= mplier_r >> 1;
            cnt_r    <= cnt_r - 1'b1;
          end
        end
        L_MUL2: begin
          acc_r <= acc_nxt;
          if (cnt_r == '0) begin
            rem_r   <= '0;
            cnt_r   <= CNT_W'(P_W - 1);
            phase_r <= L_DIV;
          end else begin
            mcand_r  <= mcand_r << 1;
            mplier_r <= mplier_r >> 1;
            cnt_r    <= cnt_r - 1'b1;
          end
        end
        L_DIV: begin
          rem_r <= fits ? diff[RW-1:0] : trial[RW-1:0];
          acc_r <= {acc_r[P_W-2:0], fits};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            phase_r <= L_IDLE;
          end
        end
        default: phase_r <= L_IDLE;
      endcase
    end
  end

  assign done = done_r;
  assign q    = acc_r;

endmodule

// File: sv/gamepad_tank_drive_mapper.sv
// Top level of the gamepad tank-drive mapper: stream channels, registers, sequencer.
//
// One gamepad report enters on the in_ stream per transfer and yields exactly one
// set of commands on the out_ stream. in_tdata carries both stick axes and the
// d-pad; out_tdata carries six H-bridge compare values, the mount angle and the
// mount servo duty. Registers are written over the APB-style cfg_ port; the user
// must write them only while the block is idle, as the block does not enforce it.
// Each report passes these steps from its transfer until out_tvalid rises: the stick
// levels and the new mount angle are formed, four bit-serial lanes that run side by
// side are started, the lanes run (a 10-step gain multiply, a 16-step period
// multiply and a 27-step division by a constant, one bit per cycle), the sequencer
// sees them finish and the output register is loaded. The block works on one
// report at a time; in_tready rises in the same cycle as out_tvalid, so a new
// report is taken only once the previous result is in the output register.
// A finished result waits in the output register while out_tready is low; the
// next report is accepted meanwhile, but its result is held in the lanes until
// the output register is free.
// Reset restores every register to its default, sets the mount angle to 90
// degrees and empties the output register.
module gamepad_tank_drive_mapper #(
  parameter int DUTY_BITS = gtd_pkg::DUTY_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // left_stick[16:0], right_stick[33:17], pad_x[35:34], pad_y[37:36]
  input  logic [39:0]                in_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // left_fwd_cmp, left_rev_cmp, right_fwd_cmp, right_rev_cmp, turret_cw_cmp,
  // turret_ccw_cmp (16 bits each), mount_deg[103:96], mount_duty[116:104]
  output logic [119:0]               out_tdata,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [gtd_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [gtd_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [gtd_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import gtd_pkg::*;

  localparam logic [M_W-1:0]   MAX_DUTY = M_W'((32'd1 << DUTY_BITS) - 32'd1);
  localparam logic [PAD_W-1:0] PAD_NONE = 2'b00;
  localparam logic [PAD_W-1:0] PAD_POS  = 2'b01;
  localparam logic [PAD_W-1:0] PAD_NEG2 = 2'b10;
  localparam logic [PAD_W-1:0] PAD_NEG  = 2'b11;
  localparam logic [G_W-1:0]   UNITY    = G_W'(1 << GAIN_FRAC);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_START,
    S_RUN,
    S_EMIT
  } state_t;

  // Configuration registers.
  logic [DZ_W-1:0]  deadzone_r;
  logic [G_W-1:0]   left_gain_r;
  logic [G_W-1:0]   right_gain_r;
  logic [CMP_W-1:0] period_r;
  logic [DEG_W-1:0] mount_min_r;
  logic [DEG_W-1:0] mount_max_r;

  logic     cfg_we;
  reg_idx_t cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[CFG_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadzone_r   <= DEADZONE_RST;
      left_gain_r  <= GAIN_RST;
      right_gain_r <= GAIN_RST;
      period_r     <= PERIOD_RST;
      mount_min_r  <= MOUNT_MIN_RST;
      mount_max_r  <= MOUNT_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_DEADZONE:   deadzone_r   <= cfg_pwdata[DZ_W-1:0];
        REG_LEFT_GAIN:  left_gain_r  <= cfg_pwdata[G_W-1:0];
        REG_RIGHT_GAIN: right_gain_r <= cfg_pwdata[G_W-1:0];
        REG_PERIOD:     period_r     <= cfg_pwdata[CMP_W-1:0];
        REG_MOUNT_MIN:  mount_min_r  <= cfg_pwdata[DEG_W-1:0];
        REG_MOUNT_MAX:  mount_max_r  <= cfg_pwdata[DEG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_DEADZONE:   cfg_prdata = CFG_DW'(deadzone_r);
      REG_LEFT_GAIN:  cfg_prdata = CFG_DW'(left_gain_r);
      REG_RIGHT_GAIN: cfg_prdata = CFG_DW'(right_gain_r);
      REG_PERIOD:     cfg_prdata = CFG_DW'(period_r);
      REG_MOUNT_MIN:  cfg_prdata = CFG_DW'(mount_min_r);
      REG_MOUNT_MAX:  cfg_prdata = CFG_DW'(mount_max_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // Stick level: zero inside the deadzone, else min(255, |y|*255 >> 15).
  function automatic logic [A_W-1:0] stick_level(logic [IN_W-1:0] y, logic [DZ_W-1:0] dz);
    logic [IN_W-1:0]            mag;
    logic [IN_W+7:0]            scaled;
    logic [IN_W+7-STICK_FRAC:0] whole;
    logic [A_W-1:0]             lvl;
    mag    = y[IN_W-1] ? (~y + 1'b1) : y;
    scaled = {mag, 8'd0} - (IN_W+8)'(mag);
    whole  = scaled[IN_W+7:STICK_FRAC];
    if (mag < IN_W'(dz)) begin
      lvl = '0;
    end else if (whole > (IN_W+8-STICK_FRAC)'(SPEED_MAX)) begin
      lvl = A_W'(SPEED_MAX);
    end else begin
      lvl = A_W'(whole);
    end
    return lvl;
  endfunction

  state_t           state_r;
  logic [IN_W-1:0]  left_in_r;
  logic [IN_W-1:0]  right_in_r;
  logic [PAD_W-1:0] pad_x_r;
  logic [PAD_W-1:0] pad_y_r;
  logic [A_W-1:0]   left_lvl_r;
  logic [A_W-1:0]   right_lvl_r;
  logic [DEG_W-1:0] angle_r;

  logic             out_tvalid_r;
  logic [CMP_W-1:0] lf_r, lr_r, rf_r, rr_r, tcw_r, tccw_r;
  logic [DEG_W-1:0] deg_r;
  logic [DUTY_W-1:0] duty_r;

  logic             in_acc;
  logic             out_free;
  logic             lane_start;

  logic signed [DEG_W+1:0] ang_sum;
  logic signed [DEG_W+1:0] ang_step;
  logic signed [DEG_W+1:0] ang_lo;
  logic [DEG_W-1:0]        ang_nxt;

  logic             l_done, r_done, t_done, d_done;
  logic [P_W-1:0]   l_q, r_q, t_q, d_q;
  logic [CMP_W-1:0] l_sat, r_sat, t_sat;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid & in_tready;
  assign out_free   = !out_tvalid_r || out_tready;
  assign lane_start = (state_r == S_START);

  always_comb begin
    case (pad_y_r)
      PAD_POS:  ang_step = (DEG_W+2)'(MOUNT_STEP);
      PAD_NEG:  ang_step = -(DEG_W+2)'(MOUNT_STEP);
      PAD_NEG2: ang_step = -(DEG_W+2)'(2 * MOUNT_STEP);
      default:  ang_step = '0;
    endcase
    ang_sum = $signed({2'b00, angle_r}) + ang_step;
    ang_lo  = (ang_sum < $signed({2'b00, mount_min_r})) ? $signed({2'b00, mount_min_r})
                                                         : ang_sum;
    ang_nxt = angle_r;
    if (pad_y_r != PAD_NONE) begin
      if (ang_lo > $signed({2'b00, mount_max_r})) begin
        ang_nxt = mount_max_r;
      end else begin
        ang_nxt = ang_lo[DEG_W-1:0];
      end
    end
  end

  gtd_lane #(.DIV_VAL(PWM_DIV)) u_left (
    .clk(clk), .rst_n(rst_n), .start(lane_start),
    .a(left_lvl_r), .g(left_gain_r), .m(period_r), .done(l_done), .q(l_q)
  );

  gtd_lane #(.DIV_VAL(PWM_DIV)) u_right (
    .clk(clk), .rst_n(rst_n), .start(lane_start),
    .a(right_lvl_r), .g(right_gain_r), .m(period_r), .done(r_done), .q(r_q)
  );

  gtd_lane #(.DIV_VAL(PWM_DIV)) u_turret (
    .clk(clk), .rst_n(rst_n), .start(lane_start),
    .a((pad_x_r != PAD_NONE) ? A_W'(TURRET_SPD) : '0), .g(UNITY), .m(period_r),
    .done(t_done), .q(t_q)
  );

  gtd_lane #(.DIV_VAL(SERVO_DIV)) u_duty (
    .clk(clk), .rst_n(rst_n), .start(lane_start),
    .a(A_W'(SERVO_OFS) + A_W'(angle_r)), .g(UNITY), .m(MAX_DUTY),
    .done(d_done), .q(d_q)
  );

  assign l_sat = (l_q > P_W'(period_r)) ? period_r : l_q[CMP_W-1:0];
  assign r_sat = (r_q > P_W'(period_r)) ? period_r : r_q[CMP_W-1:0];
  assign t_sat = (t_q > P_W'(period_r)) ? period_r : t_q[CMP_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      angle_r      <= ANGLE_RST;
    end else begin
      if (out_tvalid_r && out_tready && (state_r != S_EMIT)) begin
        out_tvalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            left_in_r  <= in_tdata[16:0];
            right_in_r <= in_tdata[33:17];
            pad_x_r    <= in_tdata[35:34];
            pad_y_r    <= in_tdata[37:36];
            state_r    <= S_PREP;
          end
        end
        S_PREP: begin
          left_lvl_r  <= stick_level(left_in_r, deadzone_r);
          right_lvl_r <= stick_level(right_in_r, deadzone_r);
          angle_r     <= ang_nxt;
          state_r     <= S_START;
        end
        S_START: begin
          state_r <= S_RUN;
        end
        S_RUN: begin
          if (l_done) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            lf_r         <= left_in_r[IN_W-1] ? '0 : l_sat;
            lr_r         <= left_in_r[IN_W-1] ? l_sat : '0;
            rf_r         <= right_in_r[IN_W-1] ? '0 : r_sat;
            rr_r         <= right_in_r[IN_W-1] ? r_sat : '0;
            tcw_r        <= (pad_x_r == PAD_POS) ? t_sat : '0;
            tccw_r       <= pad_x_r[PAD_W-1] ? t_sat : '0;
            deg_r        <= angle_r;
            duty_r       <= d_q[DUTY_W-1:0];
            out_tvalid_r <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {3'b000, duty_r, deg_r, tccw_r, tcw_r, rr_r, rf_r, lr_r, lf_r};

  a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    (l_done == r_done) && (l_done == t_done) && (l_done == d_done))
    else $error("serial lanes finished out of step");

  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    l_done |-> (state_r == S_RUN))
    else $error("lane finished outside the run state");

  a_legs_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid_r |-> ((lf_r == '0) || (lr_r == '0)) && ((rf_r == '0) || (rr_r == '0))
                     && ((tcw_r == '0) || (tccw_r == '0)))
    else $error("both legs of one bridge driven");

  a_load_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == S_EMIT))
    else $error("result loaded outside the emit state");

endmodule
